/* sv/rhs_pkg.sv */
// Shared types and constants for the rolling heat strip.
// Used by the channel interfaces, the core and the checker; no dependencies.
package rhs_pkg;

    localparam int POS_W      = 6;
    localparam int HEAT_W     = 16;
    localparam int ACC_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEAT_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_RATE    = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  led_position;
        logic [HEAT_W-1:0] heat_out;
        logic              frame_end;
    } t_res_beat;

endpackage

/* sv/rhs_if.sv */
// Valid/ready channel interfaces for the rolling heat strip: command,
// result and configuration write. Depends on rhs_pkg.
interface rhs_cmd_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

interface rhs_res_if;
    logic                       valid;
    logic                       ready;
    logic [rhs_pkg::POS_W-1:0]  led_position;
    logic [rhs_pkg::HEAT_W-1:0] heat_out;
    logic                       frame_end;

    modport source (output valid, output led_position, output heat_out, output frame_end,
                    input ready);
    modport sink   (input valid, input led_position, input heat_out, input frame_end,
                    output ready);
endinterface

interface rhs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rhs_pkg::CFG_IDX_W-1:0]  index;
    logic [rhs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rolling_heat_strip_core.sv */
// Rolling heat strip core: strip memory, fill level, roll accumulator and frame emitter.
// Depends on rhs_pkg and the channel interfaces in rhs_if.sv.
//
//  channel  | dir | beat carries                          | accepted when
//  i_cfg    | in  | index, data                           | valid & ready (ready is always 1)
//  i_cmd    | in  | advance                               | valid & ready (ready in S_IDLE)
//  o_res    | out | led_position, heat_out, frame_end     | valid & ready
//
// A frame emits STRIP_LEN beats from the strip memory at one per cycle while the output queue has room.
// A non-advancing frame goes straight to emission; an advancing one first passes S_CALC and,
// when the strip shifts, also S_SHIFT and S_FILL, with one memory write per vacated entry (up to STRIP_LEN).
// Reset clears the per-entry valid bits; there is no clearing pass.
// A two-beat output queue absorbs stalls; reads pause while it is full.
module rolling_heat_strip_core #(
    parameter int STRIP_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhs_cfg_if.sink    i_cfg,
    rhs_cmd_if.sink    i_cmd,
    rhs_res_if.source  o_res
);

    localparam int AW = $clog2(STRIP_LEN);
    localparam int CW = $clog2(STRIP_LEN + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST  = AW'(STRIP_LEN - 1);
    localparam logic [CW-1:0] LEN_C = CW'(STRIP_LEN);
    localparam logic [SW-1:0] LEN_S = SW'(STRIP_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SHIFT,
        S_FILL,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [rhs_pkg::HEAT_W-1:0]        r_heat_floor;
    logic [rhs_pkg::HEAT_W-1:0]        r_heat_ceiling;
    logic signed [rhs_pkg::HEAT_W-1:0] r_heat_step;
    logic signed [rhs_pkg::HEAT_W-1:0] r_roll_rate;

    logic [rhs_pkg::HEAT_W-1:0]       r_fill_level;
    logic signed [rhs_pkg::ACC_W-1:0] r_acc;
    logic signed [rhs_pkg::ACC_W-1:0] r_sum;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_wptr;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_rptr;
    logic [AW-1:0] r_ridx;
    logic          r_rd_pend;
    logic [AW-1:0] r_rd_pos;
    logic [AW-1:0] r_rd_phys;

    logic [rhs_pkg::HEAT_W-1:0] mem [STRIP_LEN];
    logic [STRIP_LEN-1:0]       r_vld;
    logic [rhs_pkg::HEAT_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    rhs_pkg::t_res_beat r_q [2];
    logic               r_q_head;
    logic [1:0]         r_q_cnt;

    logic cmd_acc;
    logic cfg_acc;
    logic pop;
    logic issue;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [rhs_pkg::HEAT_W-1:0] mem_wdata;

    logic signed [rhs_pkg::HEAT_W+1:0] lvl;
    logic [rhs_pkg::HEAT_W-1:0]        n_fill_level;
    logic [rhs_pkg::ACC_W-1:0]         mag;
    logic [8:0]                        whole;
    logic [7:0]                        frac;
    logic signed [rhs_pkg::ACC_W-1:0]  n_acc;
    logic [CW-1:0]                     n_cnt;
    logic [SW-1:0]                     base_sum;
    logic [AW-1:0]                     n_base;
    logic [rhs_pkg::HEAT_W-1:0]        rd_heat;
    logic [rhs_pkg::HEAT_W-1:0]        clamp_heat;
    rhs_pkg::t_res_beat                push_beat;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg.valid;
    assign cmd_acc     = i_cmd.valid && (r_state == S_IDLE);
    assign pop         = o_res.valid && o_res.ready;

    assign o_res.valid        = (r_q_cnt != 2'd0);
    assign o_res.led_position = r_q[r_q_head].led_position;
    assign o_res.heat_out     = r_q[r_q_head].heat_out;
    assign o_res.frame_end    = r_q[r_q_head].frame_end;

    always_comb begin
        lvl = $signed({2'b00, r_fill_level}) + 18'(r_heat_step);
        if (lvl > $signed({2'b00, r_heat_ceiling})) begin
            n_fill_level = r_heat_floor;
        end else if (lvl < $signed({2'b00, r_heat_floor})) begin
            n_fill_level = r_heat_ceiling;
        end else begin
            n_fill_level = lvl[rhs_pkg::HEAT_W-1:0];
        end
    end

    always_comb begin
        mag   = r_sum[rhs_pkg::ACC_W-1] ? rhs_pkg::ACC_W'(-r_sum) : rhs_pkg::ACC_W'(r_sum);
        whole = mag[16:8];
        frac  = mag[7:0];
        n_acc = r_sum[rhs_pkg::ACC_W-1] ? -$signed({9'b0, frac}) : $signed({9'b0, frac});
        n_cnt = (whole > 9'(STRIP_LEN)) ? LEN_C : CW'(whole);
    end

    always_comb begin
        if (r_neg) begin
            base_sum = SW'(r_base) + SW'(r_cnt);
        end else begin
            base_sum = SW'(r_base) + SW'(LEN_C - r_cnt);
        end
        n_base = (base_sum >= LEN_S) ? AW'(base_sum - LEN_S) : AW'(base_sum);
    end

    always_comb begin
        issue = (r_state == S_EMIT) &&
                (({1'b0, r_q_cnt} + {2'b00, r_rd_pend}) < (3'd2 + {2'b00, pop}));
        rd_heat = r_rd_vld ? r_rd_data : '0;
        if (rd_heat < r_heat_floor) begin
            clamp_heat = r_heat_floor;
        end else if (rd_heat > r_heat_ceiling) begin
            clamp_heat = r_heat_ceiling;
        end else begin
            clamp_heat = rd_heat;
        end
        push_beat.led_position = rhs_pkg::POS_W'(r_rd_pos);
        push_beat.heat_out     = clamp_heat;
        push_beat.frame_end    = (r_rd_pos == LAST);
        mem_we    = (r_state == S_FILL) || r_rd_pend;
        mem_waddr = (r_state == S_FILL) ? r_wptr : r_rd_phys;
        mem_wdata = (r_state == S_FILL) ? r_fill_level : clamp_heat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rd_data <= mem[r_rptr];
            r_rd_vld  <= r_vld[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_floor   <= '0;
            r_heat_ceiling <= '1;
            r_heat_step    <= '0;
            r_roll_rate    <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                rhs_pkg::REG_HEAT_FLOOR:   r_heat_floor   <= i_cfg.data;
                rhs_pkg::REG_HEAT_CEILING: r_heat_ceiling <= i_cfg.data;
                rhs_pkg::REG_HEAT_STEP:    r_heat_step    <= $signed(i_cfg.data);
                rhs_pkg::REG_ROLL_RATE:    r_roll_rate    <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_q[r_q_head ^ r_q_cnt[0]] <= push_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill_level <= '0;
            r_acc        <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_neg        <= 1'b0;
            r_base       <= '0;
            r_wptr       <= '0;
            r_left       <= '0;
            r_rptr       <= '0;
            r_ridx       <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_pos     <= '0;
            r_rd_phys    <= '0;
            r_q_head     <= 1'b0;
            r_q_cnt      <= '0;
        end else begin
            r_rd_pend <= issue;
            if (issue) begin
                r_rd_pos  <= r_ridx;
                r_rd_phys <= r_rptr;
                r_rptr    <= ptr_inc(r_rptr);
                r_ridx    <= r_ridx + AW'(1);
            end
            if (pop) begin
                r_q_head <= ~r_q_head;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_rd_pend} - {1'b0, pop};

            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        if (i_cmd.advance) begin
                            r_fill_level <= n_fill_level;
                            r_sum        <= r_acc + rhs_pkg::ACC_W'(r_roll_rate);
                            r_state      <= S_CALC;
                        end else begin
                            r_rptr  <= r_base;
                            r_ridx  <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_CALC: begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                    r_neg <= r_sum[rhs_pkg::ACC_W-1];
                    if (whole == 9'd0) begin
                        r_rptr  <= r_base;
                        r_ridx  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_base  <= n_base;
                    r_wptr  <= r_neg ? r_base : n_base;
                    r_left  <= r_cnt;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    r_wptr <= ptr_inc(r_wptr);
                    r_left <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_rptr  <= r_base;
                        r_ridx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (issue && (r_ridx == LAST)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/rhs_chk.sv */
// Port-level checker for the rolling heat strip result channel, with its bind.
// Depends on rhs_pkg and binds to rolling_heat_strip_core.
module rhs_chk #(
    parameter int STRIP_LEN = 64
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [rhs_pkg::POS_W-1:0]  i_led_position,
    input logic [rhs_pkg::HEAT_W-1:0] i_heat_out,
    input logic                       i_frame_end
);

    localparam logic [rhs_pkg::POS_W-1:0] LAST_POS = rhs_pkg::POS_W'(STRIP_LEN - 1);

    logic [rhs_pkg::POS_W-1:0] r_exp_pos;
    logic [rhs_pkg::POS_W-1:0] n_exp_pos;

    assign n_exp_pos = (r_exp_pos == LAST_POS) ? '0 : r_exp_pos + rhs_pkg::POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
        end else if (i_res_valid && i_res_ready) begin
            r_exp_pos <= n_exp_pos;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_led_position)
            && $stable(i_heat_out) && $stable(i_frame_end))
        else $error("stalled result beat changed");

    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_led_position == r_exp_pos)
        else $error("result beats out of position order");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_frame_end == (i_led_position == LAST_POS))
        else $error("frame end flag not on last entry");

endmodule

bind rolling_heat_strip_core rhs_chk #(.STRIP_LEN(STRIP_LEN)) u_rhs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_led_position (o_res.led_position),
    .i_heat_out     (o_res.heat_out),
    .i_frame_end    (o_res.frame_end)
);

/* tb/tb_top.sv */
// Self-checking testbench for rolling_heat_strip_core: it writes the heat and roll registers,
// sends emit and advance commands, and checks every heat beat against a model of the strip.
// Depends on rhs_pkg, the channel interfaces in rhs_if.sv and the core.
module tb_top;

    localparam int STRIP_LEN   = 64;
    localparam int RANDOM_CMDS = 220;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int DRAIN_WAIT  = 2 * STRIP_LEN + 8;

    typedef enum logic {ROW_CFG, ROW_CMD} t_row_kind;
    typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} t_sink_mode;

    typedef struct packed {
        t_row_kind                       kind;
        logic [rhs_pkg::CFG_IDX_W-1:0]   index;
        logic [rhs_pkg::CFG_DATA_W-1:0]  data;
        logic                            advance;
        logic                            flat;
        logic [rhs_pkg::HEAT_W-1:0]      flat_heat;
    } t_stim_row;

    localparam int N_ROWS = 43;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b1, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b1, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_FLOOR,   16'h0100, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b1, 16'h0100},
        '{ROW_CFG, rhs_pkg::REG_HEAT_CEILING, 16'h0200, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_STEP,    16'h0080, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'h0100, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'h0180, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'hFD80, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'h8000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_CEILING, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_STEP,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'h0040, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_STEP,    16'h8000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_FLOOR,   16'h9000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_CEILING, 16'h1000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_FLOOR,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_CEILING, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b1, 16'hFFFF},
        '{ROW_CFG, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_HEAT_STEP,    16'h0123, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG, rhs_pkg::REG_ROLL_RATE,    16'hFF00, 1'b0, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{ROW_CMD, rhs_pkg::REG_HEAT_FLOOR,   16'h0000, 1'b0, 1'b0, 16'h0000}
    };

    localparam logic [rhs_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
        rhs_pkg::REG_HEAT_FLOOR, rhs_pkg::REG_HEAT_CEILING,
        rhs_pkg::REG_HEAT_STEP, rhs_pkg::REG_ROLL_RATE
    };

    logic i_clk;
    logic i_rst_n;

    rhs_cfg_if cfg_ch ();
    rhs_cmd_if cmd_ch ();
    rhs_res_if res_ch ();

    rolling_heat_strip_core #(
        .STRIP_LEN (STRIP_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    logic [rhs_pkg::HEAT_W-1:0]        heat_floor   = '0;
    logic [rhs_pkg::HEAT_W-1:0]        heat_ceiling = '1;
    logic signed [rhs_pkg::HEAT_W-1:0] heat_step    = '0;
    logic signed [rhs_pkg::HEAT_W-1:0] roll_rate    = '0;
    logic [rhs_pkg::HEAT_W-1:0]        strip_heat [STRIP_LEN] = '{default: '0};
    logic [rhs_pkg::HEAT_W-1:0]        fill_level   = '0;
    logic signed [rhs_pkg::ACC_W-1:0]  roll_accum   = '0;

    rhs_pkg::t_res_beat heat_due [$];

    bit                         flat_check = 1'b0;
    logic [rhs_pkg::HEAT_W-1:0] flat_value = '0;
    bit                         steady_phase = 1'b0;
    int                         burst_left = 3;

    int fail_count    = 0;
    int beats_checked = 0;
    int frames_seen   = 0;
    int frames_adv    = 0;
    int regs_written  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Steps the strip model one command and queues the heat beats that frame must produce.
    function automatic void roll_and_emit(input logic adv, input bit flat,
                                          input logic [rhs_pkg::HEAT_W-1:0] flat_heat);
        int                 lvl;
        int                 acc;
        int                 whole;
        int                 n;
        rhs_pkg::t_res_beat b;
        if (adv) begin
            lvl = int'(fill_level) + int'(heat_step);
            if (lvl > int'(heat_ceiling)) begin
                lvl = int'(heat_floor);
            end else if (lvl < int'(heat_floor)) begin
                lvl = int'(heat_ceiling);
            end
            fill_level = rhs_pkg::HEAT_W'(lvl);
            acc = int'(roll_accum) + int'(roll_rate);
            whole = acc / 256;
            roll_accum = rhs_pkg::ACC_W'(acc - whole * 256);
            n = (whole < 0) ? -whole : whole;
            if (n > STRIP_LEN) n = STRIP_LEN;
            if (whole > 0) begin
                for (int i = STRIP_LEN - 1; i >= n; i--) strip_heat[i] = strip_heat[i - n];
                for (int i = 0; i < n; i++) strip_heat[i] = fill_level;
            end else if (whole < 0) begin
                for (int i = 0; i < STRIP_LEN - n; i++) strip_heat[i] = strip_heat[i + n];
                for (int i = STRIP_LEN - n; i < STRIP_LEN; i++) strip_heat[i] = fill_level;
            end
        end
        for (int i = 0; i < STRIP_LEN; i++) begin
            if (strip_heat[i] < heat_floor) begin
                strip_heat[i] = heat_floor;
            end else if (strip_heat[i] > heat_ceiling) begin
                strip_heat[i] = heat_ceiling;
            end
            b.led_position = rhs_pkg::POS_W'(i);
            b.heat_out     = flat ? flat_heat : strip_heat[i];
            b.frame_end    = (i == STRIP_LEN - 1);
            heat_due.push_back(b);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        rhs_pkg::t_res_beat want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                regs_written++;
                case (cfg_ch.index)
                    rhs_pkg::REG_HEAT_FLOOR:   heat_floor   = cfg_ch.data;
                    rhs_pkg::REG_HEAT_CEILING: heat_ceiling = cfg_ch.data;
                    rhs_pkg::REG_HEAT_STEP:    heat_step    = cfg_ch.data;
                    rhs_pkg::REG_ROLL_RATE:    roll_rate    = cfg_ch.data;
                    default: ;
                endcase
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                frames_seen++;
                if (cmd_ch.advance) frames_adv++;
                roll_and_emit(cmd_ch.advance, flat_check, flat_value);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (heat_due.size() == 0) begin
                    fail_count++;
                    $error("Heat beat with no frame pending: led_position %0d",
                           res_ch.led_position);
                end else begin
                    want = heat_due.pop_front();
                    beats_checked++;
                    check_field("led_position", want.led_position, res_ch.led_position);
                    check_field("heat_out", want.heat_out, res_ch.heat_out);
                    check_field("frame_end", want.frame_end, res_ch.frame_end);
                end
            end
        end
    end

    // The result side runs its own stall pattern, switching style after a randomly chosen span.
    initial begin
        t_sink_mode mode;
        int         span;
        int         tick;
        res_ch.ready <= 1'b0;
        mode = SINK_FREE;
        span = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = t_sink_mode'($urandom_range(0, 3));
                span = $urandom_range(50, 400);
            end
            span--;
            tick++;
            case (mode)
                SINK_FREE:  res_ch.ready <= 1'b1;
                SINK_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:    res_ch.ready <= ((tick % 7) >= 3);
            endcase
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d heat beats outstanding",
                 cycles, heat_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (heat_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rhs_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic issue_frame(input logic adv, input bit flat,
                               input logic [rhs_pkg::HEAT_W-1:0] flat_heat);
        int gap;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.advance <= adv;
        flat_check     <= flat;
        flat_value     <= flat_heat;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (!steady_phase) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 8);
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int                             random_frames;
        int                             n_frames;
        bit                             first_phase;
        logic [rhs_pkg::HEAT_W-1:0]     lo;
        logic [rhs_pkg::HEAT_W-1:0]     hi;
        logic [rhs_pkg::HEAT_W-1:0]     swap;
        logic [rhs_pkg::CFG_DATA_W-1:0] val;

        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.advance <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= rhs_pkg::REG_HEAT_FLOOR;
        cfg_ch.data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                if (r == 0 || DIRECTED[r - 1].kind == ROW_CMD) settle();
                write_reg(DIRECTED[r].index, DIRECTED[r].data);
            end else begin
                cfg_ch.valid <= 1'b0;
                issue_frame(DIRECTED[r].advance, DIRECTED[r].flat, DIRECTED[r].flat_heat);
            end
        end

        random_frames = 0;
        first_phase = 1'b1;
        while (random_frames < RANDOM_CMDS) begin
            settle();
            lo = rhs_pkg::HEAT_W'($urandom_range(0, 16'hFFFF));
            hi = rhs_pkg::HEAT_W'($urandom_range(0, 16'hFFFF));
            if (lo > hi && $urandom_range(0, 7) != 0) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            case ($urandom_range(0, 7))
                0: lo = '0;
                1: hi = '1;
                2: begin
                    lo = '0;
                    hi = '1;
                end
                default: ;
            endcase
            foreach (REG_ORDER[k]) begin
                if (first_phase || $urandom_range(0, 1) == 1) begin
                    case (REG_ORDER[k])
                        rhs_pkg::REG_HEAT_FLOOR:   val = lo;
                        rhs_pkg::REG_HEAT_CEILING: val = hi;
                        rhs_pkg::REG_HEAT_STEP: begin
                            case ($urandom_range(0, 7))
                                0:       val = 16'h7FFF;
                                1:       val = 16'h8000;
                                2, 3:    val = rhs_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                                default: val = rhs_pkg::CFG_DATA_W'($urandom_range(0, 16'h0FFF))
                                               - 16'h0800;
                            endcase
                        end
                        default: begin
                            case ($urandom_range(0, 7))
                                0:       val = 16'h7FFF;
                                1:       val = 16'h8000;
                                2:       val = rhs_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                                default: val = rhs_pkg::CFG_DATA_W'($urandom_range(0, 16'h0600))
                                               - 16'h0300;
                            endcase
                        end
                    endcase
                    write_reg(REG_ORDER[k], val);
                end
            end
            cfg_ch.valid <= 1'b0;
            first_phase = 1'b0;
            steady_phase = ($urandom_range(0, 3) == 0);
            n_frames = $urandom_range(4, 24);
            repeat (n_frames) begin
                issue_frame($urandom_range(0, 3) != 0, 1'b0, '0);
                random_frames++;
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d frames (%0d advancing) across %0d register writes and mixed stalls.",
                 frames_seen, frames_adv, regs_written);
        $display("Compared %0d heat beats field by field; %0d failures.",
                 beats_checked, fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
sv/rhs_pkg.sv
sv/rhs_if.sv
sv/rolling_heat_strip_core.sv
sv/rhs_chk.sv
tb/tb_top.sv
